>>> rtl/core/psmg_pkg.sv
// Shared widths, constants, the controller-to-datapath command type
// and the CORDIC arctangent table for polar_sighting_min_gap.
// No dependencies.
package psmg_pkg;

    // Field widths
    localparam int TIME_W      = 12;
    localparam int COORD_WIDTH = 16;
    localparam int MINUTE_W    = 11;
    localparam int DIST_W      = 24;
    localparam int BEARING_W   = 17;
    localparam int GAP_W       = 12;
    localparam int COUNT_W     = 16;

    // Fixed point
    localparam int FRAC_BITS    = 8;
    localparam int ANGLE_FRAC   = 16;
    localparam int VEC_SCALE    = 16;
    localparam int CORDIC_STEPS = 20;

    // Square root: radicand is (x*x + y*y) scaled by 2^(2*FRAC_BITS)
    localparam int SQ_W    = 2 * COORD_WIDTH;
    localparam int RAD_W   = SQ_W + 2 * FRAC_BITS;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int CNT_W   = $clog2(ROOT_W);

    // CORDIC datapath
    localparam int CORD_W  = COORD_WIDTH + VEC_SCALE + 4;
    localparam int ANGLE_W = 25;
    localparam int PHI_SUM_W = ANGLE_W - 1 + FRAC_BITS;

    // Time conversion: t / 100 as (t * 5243) >> 19, exact for 12-bit t
    localparam int HOUR_W        = 6;
    localparam int MINPART_W     = 7;
    localparam int DIV100_RECIP_W = 13;
    localparam logic [DIV100_RECIP_W-1:0] DIV100_RECIP = 13'd5243;
    localparam int DIV100_SHIFT  = 19;
    localparam int HUNDRED       = 100;
    localparam int MIN_PER_HOUR  = 60;

    localparam logic [MINUTE_W-1:0] MINUTE_MAX = 11'd1439;
    localparam logic signed [GAP_W-1:0] GAP_RESET = 12'sd1440;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic signed [ANGLE_W-1:0] ANGLE_RIGHT =
        ANGLE_W'(90 * (1 << ANGLE_FRAC));
    localparam logic signed [BEARING_W-1:0] BEARING_RIGHT =
        BEARING_W'(90 * (1 << FRAC_BITS));
    localparam logic signed [BEARING_W-1:0] BEARING_HALF =
        BEARING_W'(180 * (1 << FRAC_BITS));

    typedef struct packed {
        logic             load;      // capture item, square x
        logic             square_y;  // add y*y, seed sqrt and CORDIC
        logic             step;      // one sqrt digit, plus one CORDIC rotation while idx < CORDIC_STEPS
        logic             finish;    // load result registers, update history
        logic [CNT_W-1:0] idx;       // iteration index
    } psmg_cmd_t;

    // atan(2^-i) in degrees, Q16, rounded
    function automatic logic signed [ANGLE_W-1:0] atan_step(input logic [CNT_W-1:0] i);
        logic signed [ANGLE_W-1:0] v;
        case (i)
            5'd0:    v = 25'sd2949120;
            5'd1:    v = 25'sd1740967;
            5'd2:    v = 25'sd919879;
            5'd3:    v = 25'sd466945;
            5'd4:    v = 25'sd234379;
            5'd5:    v = 25'sd117304;
            5'd6:    v = 25'sd58666;
            5'd7:    v = 25'sd29335;
            5'd8:    v = 25'sd14668;
            5'd9:    v = 25'sd7334;
            5'd10:   v = 25'sd3667;
            5'd11:   v = 25'sd1833;
            5'd12:   v = 25'sd917;
            5'd13:   v = 25'sd458;
            5'd14:   v = 25'sd229;
            5'd15:   v = 25'sd115;
            5'd16:   v = 25'sd57;
            5'd17:   v = 25'sd29;
            5'd18:   v = 25'sd14;
            5'd19:   v = 25'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/psmg_ctrl.sv
// Sequencer for polar_sighting_min_gap: input/output handshake,
// iteration counter and datapath commands. Depends on psmg_pkg.
module psmg_ctrl
    import psmg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    output psmg_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SQUARE,
        S_RUN,
        S_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.idx        = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                cmd.square_y = 1'b1;
                cnt_next     = '0;
                state_next   = S_RUN;
            end
            S_RUN:
            begin
                cmd.step = 1'b1;
                if (cnt_reg == CNT_W'(ROOT_W - 1))
                    state_next = S_FINISH;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/core/psmg_datapath.sv
// Datapath for polar_sighting_min_gap: time conversion, shared squarer,
// digit-by-digit square root, CORDIC vectoring, gap history, result registers.
// Depends on psmg_pkg.
module psmg_datapath
    import psmg_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  psmg_cmd_t                   cmd,
    input  logic [TIME_W-1:0]           time_hhmm,
    input  logic signed [COORD_WIDTH-1:0] x_coord,
    input  logic signed [COORD_WIDTH-1:0] y_coord,
    output logic [MINUTE_W-1:0]         minutes_of_day,
    output logic [DIST_W-1:0]           distance,
    output logic signed [BEARING_W-1:0] bearing,
    output logic signed [GAP_W-1:0]     min_gap,
    output logic [COUNT_W-1:0]          item_count
);

    // working registers
    logic [MINUTE_W-1:0]           minutes_reg;
    logic signed [COORD_WIDTH-1:0] x_reg, y_reg;
    logic [SQ_W-1:0]               sq_reg;
    logic [RAD_W-1:0]              rad_reg;
    logic [REM_W-1:0]              rem_reg;
    logic [ROOT_W-1:0]             root_reg;
    logic signed [CORD_W-1:0]      a_reg, b_reg;
    logic signed [ANGLE_W-1:0]     z_reg;

    // history
    logic [MINUTE_W-1:0]           prev_min_reg, prev_min_next;
    logic signed [GAP_W-1:0]       gap_reg, gap_next;
    logic [COUNT_W-1:0]            count_reg, count_next;

    // result registers
    logic [MINUTE_W-1:0]           minutes_out_reg;
    logic [DIST_W-1:0]             dist_out_reg, dist_next;
    logic signed [BEARING_W-1:0]   bearing_out_reg, bearing_next;

    // time conversion
    logic [TIME_W+DIV100_RECIP_W-1:0] quot_prod;
    logic [HOUR_W-1:0]             hours;
    logic [TIME_W-1:0]             hundreds, minpart_full;
    logic [MINUTE_W:0]             min_sum;
    logic [MINUTE_W-1:0]           minutes_calc;

    always_comb
    begin
        quot_prod    = (TIME_W + DIV100_RECIP_W)'(time_hhmm) *
                       (TIME_W + DIV100_RECIP_W)'(DIV100_RECIP);
        hours        = quot_prod[DIV100_SHIFT +: HOUR_W];
        hundreds     = TIME_W'(hours) * TIME_W'(HUNDRED);
        minpart_full = time_hhmm - hundreds;
        min_sum      = (MINUTE_W + 1)'(hours) * (MINUTE_W + 1)'(MIN_PER_HOUR) +
                       (MINUTE_W + 1)'(minpart_full[MINPART_W-1:0]);
        if (min_sum > {1'b0, MINUTE_MAX})
            minutes_calc = MINUTE_MAX;
        else
            minutes_calc = min_sum[MINUTE_W-1:0];
    end

    // one squarer, shared between x (load) and y (square_y)
    logic signed [COORD_WIDTH-1:0] mul_in;
    logic signed [SQ_W-1:0]        mul_out;
    logic [SQ_W-1:0]               sq_sum;

    assign mul_in  = cmd.load ? x_coord : y_reg;
    assign mul_out = mul_in * mul_in;
    assign sq_sum  = sq_reg + SQ_W'(unsigned'(mul_out));

    // CORDIC seeds: |y| and |x| scaled up
    logic signed [CORD_W-1:0] ay_ext, ax_ext, a_init, b_init;

    always_comb
    begin
        ay_ext = CORD_W'(y_reg);
        ax_ext = CORD_W'(x_reg);
        a_init = (y_reg < 0 ? -ay_ext : ay_ext) <<< VEC_SCALE;
        b_init = (x_reg < 0 ? -ax_ext : ax_ext) <<< VEC_SCALE;
    end

    // square root digit: two radicand bits per step
    logic [REM_W-1:0] rem_shift, trial;
    logic             take;

    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign take      = (rem_shift >= trial);

    // CORDIC rotation, arithmetic shift rounds toward minus infinity
    logic signed [CORD_W-1:0]  da, db;
    logic signed [ANGLE_W-1:0] dz;
    logic                      cordic_on;

    assign da        = b_reg >>> cmd.idx;
    assign db        = a_reg >>> cmd.idx;
    assign dz        = atan_step(cmd.idx);
    assign cordic_on = (cmd.idx < CNT_W'(CORDIC_STEPS));

    // distance rounding: up when remainder exceeds root
    logic [ROOT_W:0] root_round;

    always_comb
    begin
        root_round = {1'b0, root_reg} + (ROOT_W + 1)'(rem_reg > REM_W'(root_reg));
        if (root_round > (ROOT_W + 1)'({DIST_W{1'b1}}))
            dist_next = '1;
        else
            dist_next = DIST_W'(root_round);
    end

    // bearing assembly
    logic [ANGLE_W-2:0]          z_clamped;
    logic [PHI_SUM_W-1:0]        phi_wide;
    logic signed [BEARING_W-1:0] phi, phi_sel;
    logic                        x_zero, y_zero;

    always_comb
    begin
        if (z_reg < 0)
            z_clamped = '0;
        else if (z_reg > ANGLE_RIGHT)
            z_clamped = ANGLE_RIGHT[ANGLE_W-2:0];
        else
            z_clamped = z_reg[ANGLE_W-2:0];
        phi_wide = {z_clamped, {FRAC_BITS{1'b0}}} + PHI_SUM_W'(1 << (ANGLE_FRAC - 1));
        phi      = signed'({1'b0, phi_wide[ANGLE_FRAC +: BEARING_W-1]});

        x_zero = (x_reg == '0);
        y_zero = (y_reg == '0);
        if (x_zero)
            phi_sel = '0;
        else if (y_zero)
            phi_sel = BEARING_RIGHT;
        else
            phi_sel = phi;

        if (x_zero && y_zero)
            bearing_next = '0;
        else if (!y_reg[COORD_WIDTH-1])
            bearing_next = x_reg[COORD_WIDTH-1] ? -phi_sel : phi_sel;
        else if (!x_reg[COORD_WIDTH-1] && !x_zero)
            bearing_next = BEARING_HALF - phi_sel;
        else
            bearing_next = phi_sel - BEARING_HALF;
    end

    // gap and count history
    logic signed [GAP_W-1:0] gap_diff;

    always_comb
    begin
        gap_diff      = signed'(GAP_W'({1'b0, minutes_reg})) -
                        signed'(GAP_W'({1'b0, prev_min_reg}));
        gap_next      = gap_reg;
        if (count_reg != '0 && gap_diff < gap_reg)
            gap_next = gap_diff;
        prev_min_next = minutes_reg;
        count_next    = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_min_reg <= '0;
            gap_reg      <= GAP_RESET;
            count_reg    <= '0;
        end
        else if (cmd.finish)
        begin
            prev_min_reg <= prev_min_next;
            gap_reg      <= gap_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            minutes_reg <= minutes_calc;
            x_reg       <= x_coord;
            y_reg       <= y_coord;
            sq_reg      <= SQ_W'(unsigned'(mul_out));
        end
        if (cmd.square_y)
        begin
            rad_reg  <= {sq_sum, {(2 * FRAC_BITS){1'b0}}};
            rem_reg  <= '0;
            root_reg <= '0;
            a_reg    <= a_init;
            b_reg    <= b_init;
            z_reg    <= '0;
        end
        if (cmd.step)
        begin
            rad_reg <= rad_reg << 2;
            if (take)
            begin
                rem_reg  <= rem_shift - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
            if (cordic_on)
            begin
                if (!b_reg[CORD_W-1])
                begin
                    a_reg <= a_reg + da;
                    b_reg <= b_reg - db;
                    z_reg <= z_reg + dz;
                end
                else
                begin
                    a_reg <= a_reg - da;
                    b_reg <= b_reg + db;
                    z_reg <= z_reg - dz;
                end
            end
        end
        if (cmd.finish)
        begin
            minutes_out_reg <= minutes_reg;
            dist_out_reg    <= dist_next;
            bearing_out_reg <= bearing_next;
        end
    end

    assign minutes_of_day = minutes_out_reg;
    assign distance       = dist_out_reg;
    assign bearing        = bearing_out_reg;
    assign min_gap        = gap_reg;
    assign item_count     = count_reg;

endmodule

>>> rtl/core/polar_sighting_min_gap.sv
// Top level of polar_sighting_min_gap: sequencer plus datapath.
// Depends on psmg_pkg, psmg_ctrl and psmg_datapath.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one item: time_hhmm, x_coord,
//   y_coord. Output channel (out_valid / out_stall) returns one result item
//   per input item: minutes_of_day, distance (Q.8), bearing (signed degrees,
//   Q.8, clockwise from north), min_gap and item_count.
//   An item is accepted on a rising edge with valid high and stall low.
//   Sequence: x is squared at the accepting edge, then y*y is added, then
//   24 square-root digit steps run with the 20 CORDIC rotations alongside,
//   then the result is assembled once the output register is free.
//   Items are taken one at a time: the 24 iterations of the digit-by-digit
//   square root set the pace, and in_stall is high while an item is in work.
//   The output register decouples the sides: a new item is taken while the
//   previous result still waits. If the receiver stalls, the finished item
//   holds in the sequencer until the output register frees up.
//   Reset (rst_n low, asynchronous) empties the block, clears the item count
//   and previous time and sets the running minimum gap to 1440.
module polar_sighting_min_gap
    import psmg_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [TIME_W-1:0]             time_hhmm,
    input  logic signed [COORD_WIDTH-1:0] x_coord,
    input  logic signed [COORD_WIDTH-1:0] y_coord,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [MINUTE_W-1:0]           minutes_of_day,
    output logic [DIST_W-1:0]             distance,
    output logic signed [BEARING_W-1:0]   bearing,
    output logic signed [GAP_W-1:0]       min_gap,
    output logic [COUNT_W-1:0]            item_count
);

    psmg_cmd_t cmd;

    // control: handshakes, iteration count, command decode
    psmg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // arithmetic and history; result registers live here
    psmg_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .time_hhmm      (time_hhmm),
        .x_coord        (x_coord),
        .y_coord        (y_coord),
        .minutes_of_day (minutes_of_day),
        .distance       (distance),
        .bearing        (bearing),
        .min_gap        (min_gap),
        .item_count     (item_count)
    );

endmodule
